// ===== design/dlrc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlrc_pkg
// Shared types, operation codes and helpers for the dual LRU result cache.
// ----------------------------------------------------------------------------
package dlrc_pkg;

  localparam int OP_W    = 2;
  localparam int HASH_W  = 64;
  localparam int CFG_W   = 5;
  localparam int COUNT_W = 32;
  localparam int DATA_W  = 64;

  localparam logic [OP_W-1:0] OP_GET   = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [HASH_W-1:0]  hash_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [DATA_W-1:0]  data_t;

  // Saturating increment of a statistics counter.
  function automatic count_t sat_inc(input count_t c);
    return (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction

endpackage

// ===== design/dlrc_ram.sv =====
// ----------------------------------------------------------------------------
// dlrc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dlrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/dual_lru_result_cache.sv =====
// ----------------------------------------------------------------------------
// dual_lru_result_cache
// Two fully associative LRU stores (hover and forward) with shared statistics.
// Steps per operation: a get miss searches the keys; a get hit and a put hit
// search, then sweep the recency ranks; a put of a new key searches, sweeps to
// place and evict, then inserts; clear and unused codes go straight to the result.
// One item at a time; the next item is taken the cycle after the result is
// registered, and a result held by the output stalls the sequencer until it
// is taken. The key search and the recency sweep each step over one entry a
// cycle, sharing one RAM read port and one rank update unit.
// Reset (synchronous, active low) empties both stores, zeroes the statistics
// and sets the capacity to 16.
// ----------------------------------------------------------------------------
module dual_lru_result_cache #(
  parameter int ENTRIES_PER_STORE = 16,
  parameter int VALUE_WIDTH       = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  dlrc_pkg::cfg_t  cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  dlrc_pkg::op_t   in_operation,
  input  logic            in_store_select,
  input  logic            in_key_kind,
  input  dlrc_pkg::hash_t in_key_hash_a,
  input  dlrc_pkg::hash_t in_key_hash_b,
  input  dlrc_pkg::data_t in_put_value,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_found,
  output dlrc_pkg::data_t out_read_value,
  output dlrc_pkg::count_t out_hit_total,
  output dlrc_pkg::count_t out_miss_total,
  output dlrc_pkg::count_t out_insert_total,
  output dlrc_pkg::count_t out_eviction_total
);

  import dlrc_pkg::*;

  localparam int N     = ENTRIES_PER_STORE;
  localparam int IW    = (N > 1) ? $clog2(N) : 1;
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int CNTW  = $clog2(N + 1);
  localparam int KEY_W = 1 + 2 * HASH_W;
  localparam int WW    = KEY_W + VALUE_WIDTH;

  localparam logic [CNTW-1:0] N_C      = CNTW'(N);
  localparam logic [IW-1:0]   LAST_IDX = IW'(N - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_TOUCH, S_PLACE, S_INSERT, S_DONE
  } state_t;

  state_t state_r;

  // Configuration and statistics.
  cfg_t   cap_r;
  count_t hit_r, miss_r, ins_r, evict_r;

  // Captured item.
  op_t                    op_r;
  logic                   sel_r;
  logic [KEY_W-1:0]       key_r;
  logic [VALUE_WIDTH-1:0] val_r;

  // Per-entry state in flip-flops.
  logic          valid_r [DEPTH];
  logic [IW-1:0] rank_r  [DEPTH];

  // Sequencer bookkeeping.
  logic [CNTW-1:0]        cnt_r;
  logic                   rd_pend_r;
  logic [IW-1:0]          rd_idx_r;
  logic [CNTW-1:0]        fill_r;
  logic                   found_r;
  logic [IW-1:0]          hit_idx_r;
  logic [IW-1:0]          hit_rank_r;
  logic [VALUE_WIDTH-1:0] hit_val_r;
  logic                   slot_found_r;
  logic [IW-1:0]          slot_r;

  // Result register.
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  count_t                 out_hit_r, out_miss_r, out_ins_r, out_evict_r;

  // RAM port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  logic [IW-1:0] sweep_idx;
  logic [AW-1:0] ent_addr;
  logic          ent_valid;
  logic [IW-1:0] ent_rank;
  logic [31:0]   cap_wide;
  logic          evicting;
  logic          ent_evict;
  logic          key_match;
  logic          out_free;
  count_t        evict_nxt;

  dlrc_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sweep_idx = cnt_r[IW-1:0];
  assign ram_raddr = {sel_r, sweep_idx};

  // One entry is looked at per cycle: the returning read during the search,
  // the swept index otherwise.
  assign ent_addr  = (state_r == S_SEARCH) ? {sel_r, rd_idx_r} : {sel_r, sweep_idx};
  assign ent_valid = valid_r[ent_addr];
  assign ent_rank  = rank_r[ent_addr];
  assign key_match = ent_valid && (ram_rdata[WW-1:VALUE_WIDTH] == key_r);

  // Capacity zero acts as one; above the store size it acts as the store size.
  always_comb begin
    if (cap_r == '0) begin
      cap_wide = 32'd1;
    end else if (32'(cap_r) > 32'(N)) begin
      cap_wide = 32'(N);
    end else begin
      cap_wide = 32'(cap_r);
    end
  end

  // A full store on insert drops every entry whose rank is at or past one less
  // than the capacity, which is exactly the oldest ones in eviction order.
  assign evicting  = 32'(fill_r) >= cap_wide;
  assign ent_evict = ent_valid && evicting && (32'(ent_rank) >= cap_wide - 32'd1);
  assign evict_nxt = sat_inc(evict_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {sel_r, slot_r};
    ram_wdata = {key_r, val_r};
    if (state_r == S_TOUCH && op_r == OP_PUT && cnt_r == '0) begin
      ram_we    = 1'b1;
      ram_waddr = {sel_r, hit_idx_r};
    end else if (state_r == S_INSERT) begin
      ram_we = 1'b1;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      hit_r       <= '0;
      miss_r      <= '0;
      ins_r       <= '0;
      evict_r     <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      // In the done state the result register is refilled below instead.
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r         <= in_operation;
            sel_r        <= in_store_select;
            key_r        <= {in_key_kind, in_key_hash_a, in_key_hash_b};
            val_r        <= in_put_value[VALUE_WIDTH-1:0];
            cnt_r        <= '0;
            rd_pend_r    <= 1'b0;
            fill_r       <= '0;
            found_r      <= 1'b0;
            slot_found_r <= 1'b0;
            if (in_operation == OP_GET || in_operation == OP_PUT) begin
              state_r <= S_SEARCH;
            end else begin
              if (in_operation == OP_CLEAR) begin
                hit_r   <= '0;
                miss_r  <= '0;
                ins_r   <= '0;
                evict_r <= '0;
                for (int i = 0; i < DEPTH; i++) begin
                  valid_r[i] <= 1'b0;
                end
              end
              state_r <= S_DONE;
            end
          end
        end

        S_SEARCH: begin
          // Reads are issued one ahead of the compare. The last compare comes
          // with the count at N, which also ends the pending reads.
          rd_pend_r <= (cnt_r < N_C);
          rd_idx_r  <= sweep_idx;
          if (cnt_r < N_C) begin
            cnt_r <= cnt_r + CNTW'(1);
          end
          if (rd_pend_r) begin
            if (ent_valid) begin
              fill_r <= fill_r + CNTW'(1);
            end
            if (key_match && !found_r) begin
              found_r    <= 1'b1;
              hit_idx_r  <= rd_idx_r;
              hit_rank_r <= ent_rank;
              hit_val_r  <= ram_rdata[VALUE_WIDTH-1:0];
            end
            if (rd_idx_r == LAST_IDX) begin
              cnt_r <= '0;
              if (found_r || key_match) begin
                state_r <= S_TOUCH;
              end else if (op_r == OP_GET) begin
                miss_r  <= sat_inc(miss_r);
                state_r <= S_DONE;
              end else begin
                state_r <= S_PLACE;
              end
            end
          end
        end

        S_TOUCH: begin
          if (sweep_idx == hit_idx_r) begin
            rank_r[ent_addr] <= '0;
          end else if (ent_valid && ent_rank < hit_rank_r) begin
            rank_r[ent_addr] <= ent_rank + IW'(1);
          end
          cnt_r <= cnt_r + CNTW'(1);
          if (sweep_idx == LAST_IDX) begin
            if (op_r == OP_GET) begin
              hit_r <= sat_inc(hit_r);
            end
            state_r <= S_DONE;
          end
        end

        S_PLACE: begin
          if (ent_evict) begin
            valid_r[ent_addr] <= 1'b0;
            evict_r           <= evict_nxt;
          end else if (ent_valid) begin
            rank_r[ent_addr] <= ent_rank + IW'(1);
          end
          if ((!ent_valid || ent_evict) && !slot_found_r) begin
            slot_found_r <= 1'b1;
            slot_r       <= sweep_idx;
          end
          cnt_r <= cnt_r + CNTW'(1);
          if (sweep_idx == LAST_IDX) begin
            state_r <= S_INSERT;
          end
        end

        S_INSERT: begin
          valid_r[{sel_r, slot_r}] <= 1'b1;
          rank_r[{sel_r, slot_r}]  <= '0;
          ins_r                    <= sat_inc(ins_r);
          state_r                  <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= found_r;
            out_value_r <= (op_r == OP_GET && found_r) ? hit_val_r : '0;
            out_hit_r   <= hit_r;
            out_miss_r  <= miss_r;
            out_ins_r   <= ins_r;
            out_evict_r <= evict_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_read_value     = DATA_W'(out_value_r);
  assign out_hit_total      = out_hit_r;
  assign out_miss_total     = out_miss_r;
  assign out_insert_total   = out_ins_r;
  assign out_eviction_total = out_evict_r;

endmodule
